// ===== rtl/core/prl_pkg.sv =====
`timescale 1ns / 1ps

package prl_pkg;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELPOS = 3'd2,
        REQ_DELKEY = 3'd3,
        REQ_LOCATE = 3'd4,
        REQ_GET    = 3'd5,
        REQ_CLEAR  = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_UP_CHK,
        S_UP_RD,
        S_UP_WR,
        S_DN_CHK,
        S_DN_RD,
        S_DN_WR,
        S_GET_RD,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_ZERO,
        IDX_HIT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_P1,
        RD_IDX_M1,
        RD_POS
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    set_st;
        status_t st;
        logic    append_wr;
        idx_op_t idx_op;
        rd_sel_t rd_sel;
        logic    shift_wr;
        logic    scan_chk;
        logic    insert_wr;
        logic    count_dec;
        logic    clear;
        logic    hit_clr;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic ins_ok;
        logic pos_ok;
        logic cnt_zero;
        logic scan_last;
        logic dn_more;
        logic up_more;
        logic hit_zero;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/positional_record_list_top.sv =====
`timescale 1ns / 1ps

// Positional record list: dense ordered list of (64-bit key, 8-bit age)
// records, up to CAPACITY entries, addressed by 1-based position.
// Input channel s_*: one request item; s_tuser carries the request type.
// Output channel m_*: one result item per request (status, found position,
// read key/age, length after the request, empty flag).
// Items are handled one at a time; s_tready is high only while idle.
// Work per request (N = entry count): append, clear, an unused type, a bad
// position, a full list and an empty-list scan need no scan or shift; get
// reads one entry; insert at p shifts entries p..N up; delete at p shifts
// entries p+1..N down; locate compares all N entries; delete by key compares
// all N, then shifts entries after the last match h down, none if no match.
// The record store has one read and one write port: each shift moves one
// entry per read/write pair, each scan step compares one entry.
// A result waits in the output register while m_tready is low; the block
// still accepts the next item and holds its result until that one is taken.
// Reset clears the list length and the handshake state; stored records
// need no clearing.
module positional_record_list_top #(
    parameter int CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // position[7:0], key[71:8], age[79:72]
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata   // status[1:0], found_position[9:2], out_key[73:10],
                                  // out_age[81:74], list_length[89:82], is_empty[90]
);
    import prl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    prl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== rtl/core/prl_ctrl.sv =====
`timescale 1ns / 1ps

module prl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  prl_pkg::stat_t stat,
    output prl_pkg::cmd_t  cmd
);
    import prl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.req)
                    REQ_INSERT: state_next = (stat.ins_ok && !stat.full) ? S_UP_CHK : S_FINISH;
                    REQ_DELPOS: state_next = stat.pos_ok ? S_DN_CHK : S_FINISH;
                    REQ_DELKEY, REQ_LOCATE: state_next = stat.cnt_zero ? S_FINISH : S_SCAN_RD;
                    REQ_GET:    state_next = stat.pos_ok ? S_GET_RD : S_FINISH;
                    default:    state_next = S_FINISH;
                endcase
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: state_next = stat.scan_last ? S_SCAN_END : S_SCAN_RD;
            S_SCAN_END:
            begin
                if (stat.req == REQ_DELKEY && !stat.hit_zero)
                begin
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_UP_CHK:   state_next = stat.up_more ? S_UP_RD : S_FINISH;
            S_UP_RD:    state_next = S_UP_WR;
            S_UP_WR:    state_next = S_UP_CHK;
            S_DN_CHK:   state_next = stat.dn_more ? S_DN_RD : S_FINISH;
            S_DN_RD:    state_next = S_DN_WR;
            S_DN_WR:    state_next = S_DN_CHK;
            S_GET_RD:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.st     = ST_OK;
        cmd.idx_op = IDX_HOLD;
        cmd.rd_sel = RD_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE:
            begin
                cmd.set_st = 1'b1;
                unique case (stat.req)
                    REQ_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.st = ST_FULL;
                        end
                        else
                        begin
                            cmd.append_wr = 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (!stat.ins_ok)
                        begin
                            cmd.st = ST_BADPOS;
                        end
                        else if (stat.full)
                        begin
                            cmd.st = ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                        end
                    end
                    REQ_DELPOS:
                    begin
                        if (!stat.pos_ok)
                        begin
                            cmd.st = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS;
                        end
                    end
                    REQ_DELKEY, REQ_LOCATE:
                    begin
                        cmd.idx_op  = IDX_ZERO;
                        cmd.hit_clr = 1'b1;
                        if (stat.cnt_zero)
                        begin
                            cmd.st = ST_NOTFOUND;
                        end
                    end
                    REQ_GET:
                    begin
                        if (!stat.pos_ok)
                        begin
                            cmd.st = ST_BADPOS;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                        cmd.st = ST_OK;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_sel = RD_IDX;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                cmd.idx_op   = IDX_INC;
            end
            S_SCAN_END:
            begin
                cmd.set_st = 1'b1;
                cmd.st     = stat.hit_zero ? ST_NOTFOUND : ST_OK;
                if (stat.req == REQ_DELKEY && !stat.hit_zero)
                begin
                    cmd.idx_op = IDX_HIT;
                end
            end
            S_UP_CHK:
            begin
                if (!stat.up_more)
                begin
                    cmd.insert_wr = 1'b1;
                end
            end
            S_UP_RD:
            begin
                cmd.rd_sel = RD_IDX_M1;
            end
            S_UP_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_op   = IDX_DEC;
            end
            S_DN_CHK:
            begin
                if (!stat.dn_more)
                begin
                    cmd.count_dec = 1'b1;
                end
            end
            S_DN_RD:
            begin
                cmd.rd_sel = RD_IDX_P1;
            end
            S_DN_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_op   = IDX_INC;
            end
            S_GET_RD:
            begin
                cmd.rd_sel = RD_POS;
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_finish_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !stat.out_free) |=> (state_reg == S_FINISH))
        else $error("finish left while result register busy");
    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_DECODE))
        else $error("captured item not decoded");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.append_wr, cmd.shift_wr, cmd.insert_wr}))
        else $error("more than one store write");
`endif

endmodule

// ===== rtl/core/prl_datapath.sv =====
`timescale 1ns / 1ps

module prl_datapath #(
    parameter int CAPACITY = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [79:0]    s_tdata,
    input  logic [2:0]     s_tuser,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [95:0]    m_tdata,
    input  prl_pkg::cmd_t  cmd,
    output prl_pkg::stat_t stat
);
    import prl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;

    logic [63:0] key_mem [CAPACITY];
    logic [7:0]  age_mem [CAPACITY];

    req_t        req_reg;
    logic [7:0]  pos_reg;
    logic [63:0] key_reg;
    logic [7:0]  age_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] hit_reg;
    status_t     st_reg;
    logic [63:0] rd_key_reg;
    logic [7:0]  rd_age_reg;
    logic        out_valid_reg;
    logic [95:0] out_data_reg;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] idx_ext;
    logic [PW-1:0] pos_m1;
    logic [PW-1:0] hit_m1;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_key;
    logic [7:0]    wr_age;
    logic [CW+7:0] hit_wide;
    logic [CW+7:0] cnt_wide;
    logic          get_ok;

    assign pos_ext  = PW'(pos_reg);
    assign cnt_ext  = PW'(count_reg);
    assign idx_ext  = PW'(idx_reg);
    assign pos_m1   = pos_ext - PW'(1);
    assign hit_m1   = PW'(hit_reg) - PW'(1);
    assign hit_wide = {8'd0, hit_reg};
    assign cnt_wide = {8'd0, count_reg};

    assign stat.req       = req_reg;
    assign stat.full      = (cnt_ext >= PW'(CAPACITY));
    assign stat.pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign stat.ins_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.scan_last = (idx_ext + PW'(1) == cnt_ext);
    assign stat.dn_more   = (idx_ext + PW'(1) < cnt_ext);
    assign stat.up_more   = (idx_ext + PW'(1) > pos_ext);
    assign stat.hit_zero  = (hit_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = idx_reg[AW-1:0];
        case (cmd.rd_sel)
            RD_IDX:    rd_addr = idx_reg[AW-1:0];
            RD_IDX_P1: rd_addr = AW'(idx_ext + PW'(1));
            RD_IDX_M1: rd_addr = AW'(idx_ext - PW'(1));
            RD_POS:    rd_addr = pos_m1[AW-1:0];
            default:   rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.append_wr || cmd.shift_wr || cmd.insert_wr;
        wr_addr = count_reg[AW-1:0];
        wr_key  = key_reg;
        wr_age  = age_reg;
        if (cmd.shift_wr)
        begin
            wr_addr = idx_reg[AW-1:0];
            wr_key  = rd_key_reg;
            wr_age  = rd_age_reg;
        end
        else if (cmd.insert_wr)
        begin
            wr_addr = pos_m1[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            age_mem[wr_addr] <= wr_age;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_age_reg <= age_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_t'(s_tuser);
            pos_reg <= s_tdata[7:0];
            key_reg <= s_tdata[71:8];
            age_reg <= s_tdata[79:72];
        end
        if (cmd.set_st)
        begin
            st_reg <= cmd.st;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append_wr || cmd.insert_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        case (cmd.idx_op)
            IDX_COUNT: idx_next = count_reg;
            IDX_POS:   idx_next = CW'(pos_m1);
            IDX_ZERO:  idx_next = '0;
            IDX_HIT:   idx_next = CW'(hit_m1);
            IDX_INC:   idx_next = idx_reg + CW'(1);
            IDX_DEC:   idx_next = idx_reg - CW'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.hit_clr)
            begin
                hit_reg <= '0;
            end
            else if (cmd.scan_chk)
            begin
                if (req_reg == REQ_DELKEY && rd_key_reg == key_reg)
                begin
                    hit_reg <= idx_reg + CW'(1);
                end
                else if (req_reg == REQ_LOCATE && hit_reg == '0 &&
                         rd_key_reg == key_reg && rd_age_reg == age_reg)
                begin
                    hit_reg <= idx_reg + CW'(1);
                end
            end
        end
    end

    assign get_ok = (req_reg == REQ_GET) && (st_reg == ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg[1:0]   <= st_reg;
            out_data_reg[9:2]   <= (req_reg == REQ_LOCATE) ? hit_wide[7:0] : 8'd0;
            out_data_reg[73:10] <= get_ok ? rd_key_reg : 64'd0;
            out_data_reg[81:74] <= get_ok ? rd_age_reg : 8'd0;
            out_data_reg[89:82] <= cnt_wide[7:0];
            out_data_reg[90]    <= (count_reg == '0);
            out_data_reg[95:91] <= 5'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished item not presented");
    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg <= CW'(CAPACITY))
        else $error("hit beyond capacity");
`endif

endmodule

// ===== tb/positional_record_list_top_tb.sv =====
`timescale 1ns / 1ps

module positional_record_list_top_tb;
    import prl_pkg::*;

    localparam int CAP = 128;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic        empty;
        logic [7:0]  length;
        logic [7:0]  rage;
        logic [63:0] rkey;
        logic [7:0]  found_pos;
        status_t     status;
    } rec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // position[7:0], key[71:8], age[79:72]
    logic [2:0]  s_tuser = '0;   // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // status, found_position, out_key, out_age, list_length, is_empty

    logic [63:0] list_key [CAP];
    logic [7:0]  list_age [CAP];
    int          list_len;
    rec_result_t pending_results [$];
    int          fail_count;
    int          idle_cycles;
    bit          calm;

    positional_record_list_top #(.CAPACITY(CAP)) uut (.*);

    always #5 clk = ~clk;

    function automatic rec_result_t apply_request(logic [2:0] req, int pos,
                                                  logic [63:0] k, logic [7:0] a);
        rec_result_t r;
        int hit;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_APPEND:
                if (list_len >= CAP) r.status = ST_FULL;
                else
                begin
                    list_key[list_len] = k;
                    list_age[list_len] = a;
                    list_len++;
                end
            REQ_INSERT:
                if (pos < 1 || pos > list_len + 1) r.status = ST_BADPOS;
                else if (list_len >= CAP) r.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos - 1; i--)
                    begin
                        list_key[i] = list_key[i-1];
                        list_age[i] = list_age[i-1];
                    end
                    list_key[pos-1] = k;
                    list_age[pos-1] = a;
                    list_len++;
                end
            REQ_DELPOS, REQ_DELKEY:
            begin
                hit = 0;
                if (req == REQ_DELPOS)
                begin
                    if (pos >= 1 && pos <= list_len) hit = pos;
                end
                else
                    for (int i = 0; i < list_len; i++)
                        if (list_key[i] == k) hit = i + 1;
                if (hit == 0) r.status = (req == REQ_DELPOS) ? ST_BADPOS : ST_NOTFOUND;
                else
                begin
                    for (int i = hit - 1; i + 1 < list_len; i++)
                    begin
                        list_key[i] = list_key[i+1];
                        list_age[i] = list_age[i+1];
                    end
                    list_len--;
                end
            end
            REQ_LOCATE:
            begin
                hit = 0;
                for (int i = 0; i < list_len; i++)
                    if (hit == 0 && list_key[i] == k && list_age[i] == a) hit = i + 1;
                if (hit == 0) r.status = ST_NOTFOUND;
                r.found_pos = hit[7:0];
            end
            REQ_GET:
                if (pos < 1 || pos > list_len) r.status = ST_BADPOS;
                else
                begin
                    r.rkey = list_key[pos-1];
                    r.rage = list_age[pos-1];
                end
            REQ_CLEAR:
                list_len = 0;
            default: ;
        endcase
        r.length = list_len[7:0];
        r.empty = (list_len == 0);
        return r;
    endfunction

    task automatic send_request(logic [2:0] req, logic [7:0] pos, logic [63:0] k,
                                logic [7:0] a);
        while (!calm && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {a, k, pos};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(apply_request(req, pos, k, a));
    endtask

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        rec_result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = rec_result_t'(m_tdata[90:0]);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.found_pos !== want.found_pos)
                begin
                    $error("found_position exp %0d got %0d", want.found_pos, got.found_pos);
                    fail_count++;
                end
                if (got.rkey !== want.rkey)
                begin
                    $error("out_key exp %h got %h", want.rkey, got.rkey);
                    fail_count++;
                end
                if (got.rage !== want.rage)
                begin
                    $error("out_age exp %0d got %0d", want.rage, got.rage);
                    fail_count++;
                end
                if (got.length !== want.length)
                begin
                    $error("list_length exp %0d got %0d", want.length, got.length);
                    fail_count++;
                end
                if (got.empty !== want.empty)
                begin
                    $error("is_empty exp %0d got %0d", want.empty, got.empty);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // pick a key already in the list most of the time
    function automatic logic [63:0] known_key();
        if (list_len > 0 && $urandom_range(3) != 0)
            return list_key[$urandom_range(list_len - 1)];
        return rand_key();
    endfunction

    task automatic test_directed();
        send_request(REQ_GET, 8'd1, '0, '0);
        send_request(REQ_DELPOS, 8'd1, '0, '0);
        send_request(REQ_DELKEY, 8'd0, '1, '0);
        send_request(REQ_LOCATE, 8'd0, '0, '0);
        send_request(REQ_INSERT, 8'd0, '1, 8'hff);
        send_request(REQ_INSERT, 8'd2, '1, 8'hff);
        send_request(REQ_APPEND, 8'hff, '1, 8'hff);
        send_request(REQ_APPEND, 8'h00, '0, 8'h00);
        send_request(REQ_INSERT, 8'd1, 64'h5555_aaaa_5555_aaaa, 8'h55);
        send_request(REQ_INSERT, 8'd4, 64'haaaa_5555_aaaa_5555, 8'haa);
        send_request(REQ_APPEND, 8'd0, '1, 8'h01);
        send_request(REQ_LOCATE, 8'd0, '1, 8'h01);
        send_request(REQ_LOCATE, 8'd0, '1, 8'h02);
        send_request(REQ_GET, 8'd5, '0, '0);
        send_request(REQ_GET, 8'd6, '0, '0);
        send_request(REQ_DELKEY, 8'd0, '1, '0);
        send_request(REQ_DELPOS, 8'd5, '0, '0);
        send_request(REQ_DELPOS, 8'd1, '0, '0);
        send_request(REQ_UNUSED, 8'hff, '1, 8'hff);
        send_request(REQ_CLEAR, 8'd0, '0, '0);
        send_request(REQ_CLEAR, 8'd0, '0, '0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < CAP; i++)
            send_request(REQ_APPEND, '0, rand_key(), 8'($urandom));
        send_request(REQ_APPEND, '0, rand_key(), 8'd7);
        send_request(REQ_INSERT, 8'd1, rand_key(), 8'd7);
        send_request(REQ_INSERT, 8'(CAP + 2), rand_key(), 8'd7);
        send_request(REQ_GET, 8'(CAP), '0, '0);
        send_request(REQ_LOCATE, '0, list_key[CAP-1], list_age[CAP-1]);
        send_request(REQ_DELPOS, 8'(CAP), '0, '0);
        send_request(REQ_INSERT, 8'(CAP), rand_key(), 8'd9);
        send_request(REQ_CLEAR, '0, '0, '0);
    endtask

    task automatic test_random(int count);
        logic [2:0] req;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            calm = (n >= count / 2 && n < count / 2 + 80);
            sel = $urandom_range(99);
            if (sel < 28) req = REQ_APPEND;
            else if (sel < 45) req = REQ_INSERT;
            else if (sel < 55) req = REQ_DELPOS;
            else if (sel < 65) req = REQ_DELKEY;
            else if (sel < 78) req = REQ_LOCATE;
            else if (sel < 95) req = REQ_GET;
            else if (sel < 97) req = REQ_CLEAR;
            else req = REQ_UNUSED;
            if ($urandom_range(9) == 0)
                send_request(req, 8'($urandom), rand_key(), 8'($urandom));
            else if (req == REQ_LOCATE && list_len > 0 && $urandom_range(2) != 0)
            begin
                sel = $urandom_range(list_len - 1);
                send_request(req, 8'($urandom), list_key[sel], list_age[sel]);
            end
            else
                send_request(req, 8'($urandom_range(list_len + 2)),
                             (req == REQ_DELKEY || req == REQ_LOCATE) ? known_key()
                                                                       : rand_key(),
                             8'($urandom));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int wait_cycles;
        list_len = 0;
        fail_count = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_random(420);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/prl_pkg.sv
rtl/core/prl_ctrl.sv
rtl/core/prl_datapath.sv
rtl/core/positional_record_list_top.sv
tb/positional_record_list_top_tb.sv
